/* design/ittx_pkg.sv */
// Package for the integer to radix text converter.
// Holds sizes, the controller state type, command and status structs and the digit glyph table.
// No dependencies.
package ittx_pkg;

    // Sizes of the datapath.
    localparam int MAX_DIGITS = 32;
    localparam int QUO_W      = 32;
    localparam int BASE_W     = 5;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 8;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W     = $clog2(MAX_DIGITS);
    localparam int DIV_BITS   = 8;
    localparam int DIV_STEPS  = QUO_W / DIV_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int SHIFT_W    = 3;

    // Characters that are not digits.
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // Base limits.
    localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

    // Digit glyphs, '0'-'9' then 'A'-'F'.
    localparam logic [CHAR_W-1:0] GLYPHS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // Controller states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SIGN = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic sign_load;
        logic rd;
        logic emit_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic digit_ready;
        logic quo_zero;
        logic count_zero;
        logic out_free;
        logic neg;
    } status_t;

    // Maps a digit value to its ASCII character.
    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        glyph = GLYPHS[d];
    endfunction

    // Forces the base into the range two to sixteen.
    function automatic logic [BASE_W-1:0] base_clamp(input logic [BASE_W-1:0] b);
        if (b < BASE_MIN)
        begin
            base_clamp = BASE_MIN;
        end
        else if (b > BASE_MAX)
        begin
            base_clamp = BASE_MAX;
        end
        else
        begin
            base_clamp = b;
        end
    endfunction

    // Shift amount for a power-of-two base; zero for any other base.
    function automatic logic [SHIFT_W-1:0] base_log2(input logic [BASE_W-1:0] b);
        case (b)
            5'd2:    base_log2 = 3'd1;
            5'd4:    base_log2 = 3'd2;
            5'd8:    base_log2 = 3'd3;
            5'd16:   base_log2 = 3'd4;
            default: base_log2 = 3'd0;
        endcase
    endfunction

endpackage

/* design/ittx_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the digit store. No dependencies.
module ittx_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/ittx_ctrl.sv */
// Controller state machine of the integer to radix text converter.
// Depends on ittx_pkg for the state type and the command and status structs.
module ittx_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  ittx_pkg::status_t st,
    output ittx_pkg::cmd_t   cmd
);

    ittx_pkg::state_t state_reg;
    ittx_pkg::state_t state_next;

    // A new item is taken only while no number is in progress.
    assign in_stall = (state_reg != ittx_pkg::S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        case (state_reg)
            ittx_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ittx_pkg::S_DIV;
                end
            end
            ittx_pkg::S_DIV:
            begin
                // Keep dividing until the quotient runs out.
                cmd.div_step = 1'b1;
                if (st.digit_ready && st.quo_zero)
                begin
                    state_next = ittx_pkg::S_SIGN;
                end
            end
            ittx_pkg::S_SIGN:
            begin
                // Emit the minus sign if asked, and fetch the top digit.
                if (!st.neg)
                begin
                    cmd.rd     = 1'b1;
                    state_next = ittx_pkg::S_EMIT;
                end
                else if (st.out_free)
                begin
                    cmd.sign_load = 1'b1;
                    cmd.rd        = 1'b1;
                    state_next    = ittx_pkg::S_EMIT;
                end
            end
            ittx_pkg::S_EMIT:
            begin
                // Present the fetched digit and fetch the next one.
                if (st.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (st.count_zero)
                    begin
                        state_next = ittx_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.rd = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ittx_pkg::S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ittx_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/ittx_datapath.sv */
// Datapath of the integer to radix text converter: divider, digit store and output register.
// Depends on ittx_pkg and on ittx_ram for the digit store.
module ittx_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ittx_pkg::cmd_t                cmd,
    output ittx_pkg::status_t             st,
    input  logic [ittx_pkg::QUO_W-1:0]    magnitude,
    input  logic [ittx_pkg::BASE_W-1:0]   base,
    input  logic                          negative,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ittx_pkg::CHAR_W-1:0]   char_out,
    output logic                          last
);

    logic [ittx_pkg::QUO_W-1:0]    quo_reg;
    logic [ittx_pkg::BASE_W-1:0]   base_reg;
    logic                          neg_reg;
    logic [ittx_pkg::DIGIT_W-1:0]  rem_reg;
    logic [ittx_pkg::STEP_W-1:0]   step_reg;
    logic [ittx_pkg::CNT_W-1:0]    count_reg;
    logic                          out_valid_reg;
    logic [ittx_pkg::CHAR_W-1:0]   char_reg;
    logic                          last_reg;

    logic [ittx_pkg::SHIFT_W-1:0]  shift_amt;
    logic                          pow2;
    logic [ittx_pkg::DIGIT_W-1:0]  mask;
    logic [ittx_pkg::DIGIT_W-1:0]  long_rem;
    logic [ittx_pkg::DIV_BITS-1:0] long_qbits;
    logic [ittx_pkg::QUO_W-1:0]    quo_next;
    logic [ittx_pkg::DIGIT_W-1:0]  digit;
    logic                          digit_ready;
    logic                          store_we;
    logic [ittx_pkg::CNT_W-1:0]    cnt_dec;
    logic [ittx_pkg::DIGIT_W-1:0]  rd_digit;
    logic                          out_free;

    // Power-of-two bases take one digit per cycle by shifting.
    assign shift_amt = ittx_pkg::base_log2(base_reg);
    assign pow2      = (shift_amt != '0);
    assign mask      = ittx_pkg::DIGIT_W'(base_reg - 1'b1);

    // Long division over one chunk of quotient bits per cycle.
    always_comb
    begin
        logic [ittx_pkg::DIGIT_W:0] trial;
        logic [ittx_pkg::DIGIT_W:0] diff;
        long_rem   = rem_reg;
        long_qbits = '0;
        for (int j = 0; j < ittx_pkg::DIV_BITS; j++)
        begin
            trial = {long_rem, quo_reg[ittx_pkg::QUO_W-1-j]};
            diff  = trial - base_reg;
            if (trial >= base_reg)
            begin
                long_rem                           = diff[ittx_pkg::DIGIT_W-1:0];
                long_qbits[ittx_pkg::DIV_BITS-1-j] = 1'b1;
            end
            else
            begin
                long_rem = trial[ittx_pkg::DIGIT_W-1:0];
            end
        end
    end

    // Quotient and digit for this cycle.
    always_comb
    begin
        if (pow2)
        begin
            quo_next = quo_reg >> shift_amt;
            digit    = quo_reg[ittx_pkg::DIGIT_W-1:0] & mask;
        end
        else
        begin
            quo_next = {quo_reg[ittx_pkg::QUO_W-ittx_pkg::DIV_BITS-1:0], long_qbits};
            digit    = long_rem;
        end
    end

    assign digit_ready = pow2 || (step_reg == ittx_pkg::STEP_W'(ittx_pkg::DIV_STEPS - 1));
    assign store_we    = cmd.div_step && digit_ready
                         && (count_reg < ittx_pkg::CNT_W'(ittx_pkg::MAX_DIGITS));
    assign cnt_dec     = count_reg - 1'b1;

    // Working registers of the division.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quo_reg  <= magnitude;
            base_reg <= ittx_pkg::base_clamp(base);
            neg_reg  <= negative;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= digit_ready ? '0 : long_rem;
        end
    end

    // Chunk counter and digit count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.load)
        begin
            step_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.div_step && !pow2)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (store_we)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.rd)
            begin
                count_reg <= cnt_dec;
            end
        end
    end

    // Digit store, least significant digit at entry zero.
    ittx_ram #(
        .WIDTH (ittx_pkg::DIGIT_W),
        .DEPTH (ittx_pkg::MAX_DIGITS)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (count_reg[ittx_pkg::ADDR_W-1:0]),
        .wdata (digit),
        .re    (cmd.rd),
        .raddr (cnt_dec[ittx_pkg::ADDR_W-1:0]),
        .rdata (rd_digit)
    );

    // Output register; it may be reloaded in the cycle its item is taken.
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.sign_load || cmd.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sign_load)
        begin
            char_reg <= ittx_pkg::CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            char_reg <= ittx_pkg::glyph(rd_digit);
            last_reg <= (count_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;

    // Status back to the controller.
    assign st.digit_ready = digit_ready;
    assign st.quo_zero    = (quo_next == '0);
    assign st.count_zero  = (count_reg == '0);
    assign st.out_free    = out_free;
    assign st.neg         = neg_reg;

endmodule

/* design/integer_to_radix_text_core.sv */
// Top level of the integer to radix text converter.
// Depends on ittx_pkg, ittx_ctrl and ittx_datapath.
//
// Usage:
// The input channel (in_valid, in_stall) carries magnitude, base and negative.
// An item is taken when in_valid is high and in_stall is low. The output
// channel (out_valid, out_stall) carries one ASCII character per item in
// char_out, most significant digit first, with '-' ahead when negative is
// set; last marks the final character of the number. Bases below two count
// as two and bases above sixteen as sixteen.
// The item is taken in the idle state. Bases 2, 4, 8 and 16 then yield their
// digits by shifting, other bases by long division in the divider, which
// handles eight quotient bits per cycle and so runs through the whole quotient
// for each digit. After the last division step the sign state loads the minus
// sign, if any, into the output register and fetches the top digit; the emit
// state loads that digit, and one character follows each cycle while the
// receiver does not stall. Throughput: one number at a time, of at most 33
// characters; the next item is taken only once the last character is in the
// output register. A stall on the output holds the current character and
// pauses the controller. Reset clears the controller, the digit count and
// the output valid; no clearing pass.
module integer_to_radix_text_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ittx_pkg::QUO_W-1:0]  magnitude,
    input  logic [ittx_pkg::BASE_W-1:0] base,
    input  logic                        negative,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ittx_pkg::CHAR_W-1:0] char_out,
    output logic                        last
);

    ittx_pkg::cmd_t    cmd;
    ittx_pkg::status_t st;

    // Controller.
    ittx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath.
    ittx_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .magnitude (magnitude),
        .base      (base),
        .negative  (negative),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_out  (char_out),
        .last      (last)
    );

`ifndef SYNTH
    // A new number starts only when no digits of the previous one remain.
    a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> st.count_zero)
        else $error("item taken while digits remain in the store");

    // The output register is never overwritten while its item waits.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sign_load || cmd.emit_load) |-> st.out_free)
        else $error("output register reloaded while stalled");

    // A stalled character holds until it is taken.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(char_out) && $stable(last)))
        else $error("character changed while stalled");

    // The final character is always a digit.
    a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (char_out != ittx_pkg::CHAR_MINUS))
        else $error("minus sign marked as final character");
`endif

endmodule

/* test/integer_to_radix_text_core_tb.sv */
// Testbench for integer_to_radix_text_core: numbers in, ASCII characters out.
// A directed table checks its own texts or the text predictor; a random run uses the predictor.
// Depends on ittx_pkg and the integer_to_radix_text_core RTL.
`timescale 1ns / 100ps

module integer_to_radix_text_core_tb;

    localparam int QW = ittx_pkg::QUO_W;
    localparam int BW = ittx_pkg::BASE_W;
    localparam int CW = ittx_pkg::CHAR_W;

    localparam logic [CW-1:0] ASCII_ZERO    = 8'h30;
    localparam logic [CW-1:0] ASCII_UPPER_A = 8'h41;

    localparam int RANDOM_NUMBERS = 300;
    localparam int DRAIN_CYCLES   = 200;
    localparam int CYCLE_LIMIT    = 1200000;
    localparam int REPORT_MAX     = 10;
    localparam int TABLE_ROWS     = 24;

    // One expected character of the output text.
    typedef struct packed {
        logic [CW-1:0] ch;
        logic          fin;
    } text_char_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [QW-1:0] magnitude;
    logic [BW-1:0] base;
    logic          negative;
    logic          out_valid;
    logic          out_stall;
    logic [CW-1:0] char_out;
    logic          last;

    text_char_t pending_text [$];
    int         fail_count;
    int         cycle_count = 0;
    bit         no_idle;

    // Directed table. An empty text means the row is checked by the predictor.
    logic [QW-1:0] row_mag [TABLE_ROWS] = '{
        32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0000_0005,
        32'h0000_0005, 32'h0000_00FF, 32'h00AB_CDEF, 32'h0000_00DC,
        32'h0000_0001, 32'h0000_000F, 32'h0000_0010, 32'hFFFF_FFFF,
        32'd12345,     32'hFFFF_FFFF, 32'd1000000,   32'hDEAD_BEEF,
        32'd123456789, 32'd9,         32'hFFFF_FFFF, 32'h0000_0000
    };
    logic [BW-1:0] row_base [TABLE_ROWS] = '{
        5'd10, 5'd10, 5'd2,  5'd16, 5'd10, 5'd16, 5'd2,  5'd0,
        5'd1,  5'd31, 5'd17, 5'd16, 5'd2,  5'd16, 5'd16, 5'd8,
        5'd10, 5'd3,  5'd7,  5'd13, 5'd11, 5'd9,  5'd5,  5'd31
    };
    logic row_neg [TABLE_ROWS] = '{
        1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0
    };
    string row_text [TABLE_ROWS] = '{
        "0",
        "-0",
        "11111111111111111111111111111111",
        "FFFFFFFF",
        "-4294967295",
        "-80000000",
        "10000000000000000000000000000000",
        "101",
        "-101",
        "FF",
        "ABCDEF",
        "DC",
        "1",
        "F",
        "10",
        "37777777777",
        "12345",
        "",
        "",
        "",
        "",
        "10",
        "",
        "0"
    };

    integer_to_radix_text_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .magnitude (magnitude),
        .base      (base),
        .negative  (negative),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_out  (char_out),
        .last      (last)
    );

    // Free-running clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("integer_to_radix_text_core_tb NOT OK");
            $finish;
        end
    end

    // Predicts the text of one number and queues its characters.
    function automatic void predict_text(input logic [QW-1:0] mag, input logic [BW-1:0] b,
                                         input logic neg);
        logic [QW-1:0] radix;
        logic [QW-1:0] quo;
        logic [QW-1:0] rem;
        logic [3:0]    digits [64];
        int            n;
        text_char_t    item;
        radix = (b < 2) ? 2 : ((b > 16) ? 16 : {{(QW-BW){1'b0}}, b});
        quo = mag;
        n = 0;
        // Digits come out least significant first; extra ones are dropped when the store is full.
        do
        begin
            rem = quo % radix;
            quo = quo / radix;
            if (n < ittx_pkg::MAX_DIGITS)
            begin
                digits[n] = rem[3:0];
                n++;
            end
        end
        while (quo != 0);
        if (neg)
        begin
            item.ch = ittx_pkg::CHAR_MINUS;
            item.fin = 1'b0;
            pending_text.push_back(item);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            item.ch = CW'((digits[i] < 10) ? ASCII_ZERO + digits[i]
                                           : ASCII_UPPER_A + digits[i] - 10);
            item.fin = (i == 0);
            pending_text.push_back(item);
        end
    endfunction

    // Queues a literal expected text.
    function automatic void queue_literal(input string text);
        text_char_t item;
        for (int i = 0; i < text.len(); i++)
        begin
            item.ch = text[i];
            item.fin = (i == text.len() - 1);
            pending_text.push_back(item);
        end
    endfunction

    // Compares one received character against the oldest expectation.
    task automatic check_char(input logic [CW-1:0] got_ch, input logic got_last);
        text_char_t want;
        if (pending_text.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
            begin
                $display("unexpected character %h last %b", got_ch, got_last);
            end
        end
        else
        begin
            want = pending_text.pop_front();
            if (got_ch !== want.ch || got_last !== want.fin)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                begin
                    $display("character mismatch: expected %h last %b, got %h last %b",
                             want.ch, want.fin, got_ch, got_last);
                end
            end
        end
    endtask

    // Presents one number after a random gap and waits until it is taken.
    task automatic offer_number(input logic [QW-1:0] mag, input logic [BW-1:0] b,
                                input logic neg, input string text);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (text.len() == 0)
        begin
            predict_text(mag, b, neg);
        end
        else
        begin
            queue_literal(text);
        end
        in_valid  <= 1'b1;
        magnitude <= mag;
        base      <= b;
        negative  <= neg;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Holds off new numbers until every queued character has arrived.
    task automatic wait_all_text;
        in_valid <= 1'b0;
        while (pending_text.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Random magnitude with a spread of digit counts.
    function automatic logic [QW-1:0] pick_magnitude;
        case ($urandom_range(0, 9))
            0:       pick_magnitude = '0;
            1:       pick_magnitude = $urandom_range(0, 20);
            2:       pick_magnitude = 32'hFFFF_FFFF - $urandom_range(0, 3);
            3:       pick_magnitude = 32'h8000_0000;
            default: pick_magnitude = $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    // Receiver: random stalls per character, then takes one character.
    initial
    begin
        int hold;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 19);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
            check_char(char_out, last);
        end
    end

    // Sender: reset, directed table, random numbers, then drain and report.
    initial
    begin
        logic [BW-1:0] b;
        fail_count  = 0;
        no_idle     = 1'b0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        magnitude  <= '0;
        base       <= '0;
        negative   <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < TABLE_ROWS; r++)
        begin
            offer_number(row_mag[r], row_base[r], row_neg[r], row_text[r]);
        end
        wait_all_text();

        // Random part; every third stretch of 40 numbers runs with no idling.
        for (int i = 0; i < RANDOM_NUMBERS; i++)
        begin
            no_idle = ((i / 40) % 3 == 2);
            if (i == RANDOM_NUMBERS / 2)
            begin
                wait_all_text();
            end
            b = BW'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(2, 16));
            offer_number(pick_magnitude(), b, 1'($urandom_range(0, 1)), "");
        end
        in_valid <= 1'b0;

        while (pending_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("integer_to_radix_text_core_tb OK");
        end
        else
        begin
            $display("integer_to_radix_text_core_tb NOT OK");
        end
        $finish;
    end

endmodule

/* integer_to_radix_text_core.f */
design/ittx_pkg.sv
design/ittx_ram.sv
design/ittx_ctrl.sv
design/ittx_datapath.sv
design/integer_to_radix_text_core.sv
test/integer_to_radix_text_core_tb.sv
